// ===== rtl/bounded_array_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// Bounded array list assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_TOP_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge out of reset.
`define BAL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define BAL_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BAL_ASSERT(name, prop, msg)
`define BAL_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

// ===== rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded array list package
// Sizes, request and status codes, and the structs shared by the list blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package bal_pkg;

  // List capacity and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result channels.
  localparam int REQ_W   = 3;
  localparam int POS_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 5;
  localparam int IDX_W   = 4;

  // Width used to compare a request position against the entry count.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_DUMP   = 3'd4
  } req_e;

  // Status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_GAP   = 2'd3
  } status_e;

  // One result item as produced by the sequencer.
  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] count;
    logic [IDX_W-1:0]   index;
    logic [DATA_W-1:0]  value;
    logic               last;
  } res_t;

  // Access to the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/bal_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bal_seq.sv =====
// ----------------------------------------------------------------------------
// Bounded array list sequencer
// Decodes a request and walks the entry memory with one shared pointer
// stepper, one entry move or one dump read at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_array_list_top_macros.svh"

module bal_seq
  import bal_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [DATA_W-1:0] value_i,
  output ram_req_t               ram_o,
  input  wire logic [DATA_W-1:0] ram_rdata_i,
  output logic                   emit_valid_o,
  input  wire logic              emit_ready_i,
  output res_t                   emit_o
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECODE    = 8'b0000_0010,
    S_WRITE     = 8'b0000_0100,
    S_SHIFT_RD  = 8'b0000_1000,
    S_SHIFT_WR  = 8'b0001_0000,
    S_DUMP_RD   = 8'b0010_0000,
    S_DUMP_EMIT = 8'b0100_0000,
    S_RESULT    = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ST_W-1:0]   status_q, status_d;
  logic              dir_q, dir_d;

  logic [ADDR_W-1:0] step;
  logic [ADDR_W-1:0] last_idx;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic              full;
  logic              empty;

  // Shared pointer stepper: down toward the insert point, else up.
  assign step     = dir_q ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
  assign last_idx = ADDR_W'(count_q - 1'b1);
  assign cnt_ext  = CMP_W'(count_q);
  assign pos_ext  = CMP_W'(pos_q);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);

  // Next-state and datapath control.
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    pos_d    = pos_q;
    val_d    = val_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    status_d = status_q;
    dir_d    = dir_q;

    in_ready_o   = (state_q == S_IDLE);
    ram_o.we     = 1'b0;
    ram_o.waddr  = ptr_q;
    ram_o.wdata  = val_q;
    ram_o.re     = 1'b0;
    ram_o.raddr  = step;
    emit_valid_o = 1'b0;
    emit_o.status = status_q;
    emit_o.count  = COUNT_W'(count_q);
    emit_o.index  = '0;
    emit_o.value  = '0;
    emit_o.last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          pos_d   = position_i;
          val_d   = value_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d = ST_OK;
        state_d  = S_RESULT;
        case (req_e'(req_q))
          REQ_PUSH: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ptr_d   = ADDR_W'(count_q);
              state_d = S_WRITE;
            end
          end
          REQ_POP: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
            end
          end
          REQ_INSERT: begin
            if (full) begin
              status_d = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              status_d = ST_GAP;
            end else begin
              ptr_d   = ADDR_W'(count_q);
              dir_d   = 1'b1;
              state_d = (pos_ext == cnt_ext) ? S_WRITE : S_SHIFT_RD;
            end
          end
          REQ_REMOVE: begin
            if (empty || (pos_ext >= cnt_ext)) begin
              status_d = ST_EMPTY;
            end else begin
              ptr_d = ADDR_W'(pos_q);
              dir_d = 1'b0;
              if ((pos_ext + CMP_W'(1)) == cnt_ext) begin
                count_d = count_q - 1'b1;
              end else begin
                state_d = S_SHIFT_RD;
              end
            end
          end
          REQ_DUMP: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              ptr_d   = '0;
              dir_d   = 1'b0;
              state_d = S_DUMP_RD;
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end

      // Fetch the neighbor that moves into the pointer slot.
      S_SHIFT_RD: begin
        ram_o.re = 1'b1;
        state_d  = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        ram_o.we    = 1'b1;
        ram_o.wdata = ram_rdata_i;
        ptr_d       = step;
        if (dir_q) begin
          state_d = (step == ADDR_W'(pos_q)) ? S_WRITE : S_SHIFT_RD;
        end else if (step == last_idx) begin
          count_d = count_q - 1'b1;
          state_d = S_RESULT;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end

      // Store the new word for push or insert.
      S_WRITE: begin
        ram_o.we = 1'b1;
        count_d  = count_q + 1'b1;
        state_d  = S_RESULT;
      end

      S_DUMP_RD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = ptr_q;
        state_d     = S_DUMP_EMIT;
      end

      S_DUMP_EMIT: begin
        emit_valid_o  = 1'b1;
        emit_o.status = ST_OK;
        emit_o.index  = IDX_W'(ptr_q);
        emit_o.value  = ram_rdata_i;
        emit_o.last   = (ptr_q == last_idx);
        if (emit_ready_i) begin
          if (ptr_q == last_idx) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = step;
            state_d = S_DUMP_RD;
          end
        end
      end

      S_RESULT: begin
        emit_valid_o = 1'b1;
        if (emit_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Request and walk registers.
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    dir_q    <= dir_d;
  end

  `BAL_ASSERT(a_count_bound, count_q <= CAPACITY, "entry count exceeds capacity")
  `BAL_ASSERT(a_waddr_bound, !ram_o.we || (ram_o.waddr < CAPACITY), "write beyond capacity")
  `BAL_ASSERT(a_count_step, (count_q == $past(count_q)) || (count_q == $past(count_q) + 1) || (count_q + 1 == $past(count_q)), "entry count moved by more than one")
  `BAL_ASSERT_NEXT(a_accept_decode, in_valid_i && in_ready_o, state_q == S_DECODE, "accepted request not decoded")

endmodule

`default_nettype wire

// ===== rtl/bounded_array_list_top.sv =====
// Push and an insert at the end pass through decode, write and result; pop, a remove
// of the last entry, refused requests and unused codes pass through decode and result. Other
// inserts and removes add one memory read and one write per entry moved before the result.
// A dump reads each entry and then emits it as a result, one entry at a time.
// Input is accepted again as soon as the last result sits in the output register.
// Reset empties the list at once; entry storage is not cleared.
`default_nettype none
`include "bounded_array_list_top_macros.svh"

// ----------------------------------------------------------------------------
// Bounded array list
// Ordered list of signed words with push, pop, insert, remove and dump
// requests, entries held in a RAM and walked by a sequencer.
// ----------------------------------------------------------------------------
module bounded_array_list_top
  import bal_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [REQ_W-1:0]         req_type_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ST_W-1:0]               status_o,
  output logic [COUNT_W-1:0]            count_o,
  output logic [IDX_W-1:0]              out_index_o,
  output logic signed [DATA_W-1:0]      out_value_o,
  output logic                          last_o
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              emit_valid;
  logic              emit_ready;
  res_t              emit;
  res_t              out_q;
  logic              out_valid_q;

  bal_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .ram_o        (ram_req),
    .ram_rdata_i  (ram_rdata),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_o       (emit)
  );

  bal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a new result when empty or being drained.
  assign emit_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign count_o     = out_q.count;
  assign out_index_o = out_q.index;
  assign out_value_o = out_q.value;
  assign last_o      = out_q.last;

  `BAL_ASSERT(a_no_emit_on_accept, !(in_valid_i && in_ready_o) || !emit_valid, "request accepted while a result is produced")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Bounded array list testbench
// Drives push, pop, insert, remove and dump requests with random gaps and
// stalls on both channels. A scoreboard keeps its own copy of the list,
// predicts every result, and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bal_pkg::*;

  // Request codes that the block treats as a no-op.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  // Run limit in clock cycles and the settle time after the last result.
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_TICKS = 40;

  // Keeps a shadow copy of the list and the results that it still expects.
  class list_scoreboard;
    logic [DATA_W-1:0] slots [CAPACITY];
    int unsigned       len;
    res_t              expected_q [$];
    int unsigned       errors;

    // Applies an accepted request to the shadow list and queues its results.
    function void note_request(logic [REQ_W-1:0] rt, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val);
      res_t        r;
      int unsigned k;
      r        = '0;
      r.status = ST_OK;
      r.last   = 1'b1;
      case (rt)
        REQ_PUSH: begin
          if (len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[len] = val;
            len++;
          end
        end
        REQ_POP: begin
          if (len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            len--;
          end
        end
        REQ_INSERT: begin
          // The full check wins over the position check.
          if (len >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (pos > len) begin
            r.status = ST_GAP;
          end else begin
            for (k = len; k > pos; k--) begin
              slots[k] = slots[k-1];
            end
            slots[pos] = val;
            len++;
          end
        end
        REQ_REMOVE: begin
          if (len == 0 || pos >= len) begin
            r.status = ST_EMPTY;
          end else begin
            for (k = pos; k + 1 < len; k++) begin
              slots[k] = slots[k+1];
            end
            len--;
          end
        end
        REQ_DUMP: begin
          // A non-empty dump gives one result per entry; an empty one falls through.
          if (len == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (k = 0; k < len; k++) begin
              r.count  = COUNT_W'(len);
              r.index  = IDX_W'(k);
              r.value  = slots[k];
              r.last   = (k + 1 == len);
              expected_q.push_back(r);
            end
            return;
          end
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(len);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compares an accepted result with the oldest expected one.
    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d count %0d index %0d value %0h last %0b",
                 $time, got.status, got.count, got.index, got.value, got.last);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("count", want.count, got.count);
      compare_field("out_index", want.index, got.index);
      compare_field("out_value", want.value, got.value);
      compare_field("last", want.last, got.last);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [REQ_W-1:0]         req_type_i  = '0;
  logic [POS_W-1:0]         position_i  = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [ST_W-1:0]          status_o;
  logic [COUNT_W-1:0]       count_o;
  logic [IDX_W-1:0]         out_index_o;
  logic signed [DATA_W-1:0] out_value_o;
  logic                     last_o;

  list_scoreboard sb;
  res_t           seen;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  int unsigned    hold_left     = 0;
  int unsigned    cycles        = 0;

  bounded_array_list_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .position_i (position_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .count_o    (count_o),
    .out_index_o(out_index_o),
    .out_value_o(out_value_o),
    .last_o     (last_o)
  );

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Ends the run as failed if it goes on far too long.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_left counts down.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.status = status_o;
      seen.count  = count_o;
      seen.index  = out_index_o;
      seen.value  = out_value_o;
      seen.last   = last_o;
      sb.check_result(seen);
    end
  end

  // Offers one request after an optional random gap and waits for acceptance.
  // Valid stays high afterwards so that back-to-back requests need no gap.
  task automatic send_request(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rt, pos, val);
  endtask

  // Stops offering and waits until every expected result has come.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Random request, mostly well-formed for the current list length.
  task automatic send_random(input int unsigned grow_pct);
    int unsigned       n;
    int unsigned       roll;
    logic [REQ_W-1:0]  rt;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    n    = sb.len;
    roll = $urandom_range(99);
    pos  = POS_W'($urandom_range(15));
    val  = $urandom;
    case ($urandom_range(19))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'hFFFF_FFFF;
      3: val = '0;
      default: begin
      end
    endcase
    if (roll < 6) begin
      rt = REQ_DUMP;
    end else if (roll < 9) begin
      rt = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    end else if ($urandom_range(99) < grow_pct) begin
      if ($urandom_range(1) == 0) begin
        rt = REQ_PUSH;
      end else begin
        rt = REQ_INSERT;
        if ($urandom_range(9) != 0) begin
          pos = POS_W'($urandom_range((n > 15) ? 15 : n));
        end
      end
    end else begin
      if ($urandom_range(1) == 0) begin
        rt = REQ_POP;
      end else begin
        rt = REQ_REMOVE;
        if (n > 0 && $urandom_range(9) != 0) begin
          pos = POS_W'($urandom_range(n - 1));
        end
      end
    end
    send_request(rt, pos, val);
  endtask

  // Fills the list, probes the full cases and the widest dump, then trims it.
  task automatic fill_and_probe();
    while (sb.len < CAPACITY) begin
      send_request(REQ_PUSH, POS_W'($urandom_range(15)), $urandom);
    end
    send_request(REQ_PUSH, 4'd0, $urandom);
    send_request(REQ_INSERT, 4'd15, $urandom);
    send_request(REQ_INSERT, 4'd0, $urandom);
    send_request(REQ_DUMP, 4'd0, '0);
    send_request(REQ_REMOVE, 4'd15, '0);
    send_request(REQ_REMOVE, 4'd0, '0);
    send_request(REQ_INSERT, 4'd14, $urandom);
    send_request(REQ_POP, 4'd0, '0);
  endtask

  initial begin
    int unsigned grow;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests: empty-list refusals, no-op codes, edge positions
    // and the extreme values.
    send_request(REQ_POP, 4'd0, '0);
    send_request(REQ_REMOVE, 4'd0, '0);
    send_request(REQ_DUMP, 4'd0, '0);
    send_request(REQ_UNUSED_LO, 4'd9, 32'h1234_5678);
    send_request(REQ_UNUSED_HI, 4'd15, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 4'd1, 32'h5555_5555);
    send_request(REQ_INSERT, 4'd0, 32'h7FFF_FFFF);
    send_request(REQ_PUSH, 4'd15, 32'h8000_0000);
    send_request(REQ_INSERT, 4'd2, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 4'd1, '0);
    send_request(REQ_INSERT, 4'd15, 32'hAAAA_AAAA);
    send_request(REQ_REMOVE, 4'd4, '0);
    send_request(REQ_REMOVE, 4'd15, '0);
    send_request(REQ_REMOVE, 4'd1, '0);
    send_request(REQ_DUMP, 4'd0, '0);
    send_request(REQ_POP, 4'd0, '0);
    send_request(REQ_REMOVE, 4'd0, '0);
    send_request(REQ_DUMP, 4'd0, '0);
    wait_drain();

    fill_and_probe();
    wait_drain();

    // Random phases: no idling, idle sender, stalling receiver, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 57 : (phase == 3) ? 7 : 0;
      stall_pct     = (phase == 2) ? 57 : (phase == 3) ? 7 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        case ($urandom_range(2))
          0: grow = 20;
          1: grow = 50;
          default: grow = 85;
        endcase
        repeat (23) send_random(grow);
      end
      wait_drain();
    end

    // Long receiver hold-off while requests keep coming, so the input backs up.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    repeat (24) send_random(70);
    wait_drain();

    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
